// ----- src/cts_pkg.sv -----
package cts_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  // Status codes of a result word
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam int TAG_W    = 8;
  localparam int TIME_W   = 16;
  localparam int PEND_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int IDX_W    = 4;

  // Dispatch emits at most this many words per item
  localparam int RESULT_LIMIT = 16;
  localparam int NCNT_W       = $clog2(RESULT_LIMIT + 1);

  localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [PEND_W-1:0] pend;
  } slot_data_t;

  typedef struct packed {
    logic       valid;
    slot_data_t data;
  } slot_t;

  // Control handed from the sequencer to the head unit
  typedef struct packed {
    op_t               op;
    logic              add_done;
    logic              del_hit;
    logic              disp_allow;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
  } head_ctl_t;

endpackage

// ----- src/cts_cell.sv -----
module cts_cell
  import cts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  slot_t d_in,
  output slot_t q
);

  logic       valid_r;
  slot_data_t data_r;

  // Take the neighbor's slot on every shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in.data;
    end
  end

  assign q.valid = valid_r;
  assign q.data  = data_r;

endmodule

// ----- src/cts_head.sv -----
module cts_head
  import cts_pkg::*;
(
  input  slot_t     slot_in,
  input  head_ctl_t ctl,
  output slot_t     slot_out,
  output logic      hit
);

  always_comb begin
    slot_out = slot_in;
    hit      = 1'b0;
    case (ctl.op)
      OP_ADD: begin
        if (!slot_in.valid && !ctl.add_done) begin
          hit                  = 1'b1;
          slot_out.valid       = 1'b1;
          slot_out.data.tag    = ctl.tag;
          slot_out.data.delay  = ctl.delay;
          slot_out.data.period = ctl.period;
          slot_out.data.pend   = '0;
        end
      end
      OP_DEL: begin
        if (slot_in.valid && ctl.del_hit) begin
          hit      = 1'b1;
          slot_out = '0;
        end
      end
      OP_TICK: begin
        if (slot_in.valid) begin
          if (slot_in.data.delay == '0) begin
            if (slot_in.data.pend != PEND_MAX) begin
              slot_out.data.pend = slot_in.data.pend + 1'b1;
            end
            slot_out.data.delay = slot_in.data.period;
          end else begin
            slot_out.data.delay = slot_in.data.delay - 1'b1;
          end
        end
      end
      OP_DISP: begin
        if (slot_in.valid && slot_in.data.pend != '0 && ctl.disp_allow) begin
          hit                = 1'b1;
          slot_out.data.pend = slot_in.data.pend - 1'b1;
          // one-shot task: free the slot
          if (slot_in.data.period == '0) begin
            slot_out = '0;
          end
        end
      end
      default: begin
        slot_out = slot_in;
      end
    endcase
  end

endmodule

// ----- src/cooperative_task_scheduler.sv -----
// Cooperative task scheduler. The task table lives in a ring of MAX_TASKS
// slot cells. Every command (add, delete, tick, dispatch) turns the ring once:
// each cycle the slot at the head passes through one update unit and moves to
// the tail. The pass (S_RUN) is followed by the S_DONE state, which forms
// the closing word; busy is high through both and start is taken only while
// busy is low. The closing word shows in the cycle right after S_DONE, when
// busy is already low. Every result word is shown for exactly one cycle with
// out_valid high, and the receiver cannot stall: capture it in that cycle or
// lose it. Add, delete and tick give one word at the end of the pass.
// Dispatch gives one word per ready slot in slot order (up to 16); each is
// held until the head unit finds the next ready slot or the pass ends, with
// out_last set on the final word; when nothing is ready it gives one word
// with status "nothing ready". The slot field carries the low four bits of
// the slot number.
module cooperative_task_scheduler
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [TAG_W-1:0]  in_task_tag,
  input  logic [TIME_W-1:0] in_first_delay,
  input  logic [TIME_W-1:0] in_repeat_period,
  input  logic [IDX_W-1:0]  in_slot_index,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [TAG_W-1:0]  out_run_tag,
  output logic              out_last
);

  localparam int CW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CW-1:0] CNT_END = CW'(MAX_TASKS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // latched command word
  op_t               op_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] delay_r;
  logic [TIME_W-1:0] period_r;
  logic [IDX_W-1:0]  idx_r;

  logic [CW-1:0]     cnt_r;
  logic              add_done_r;
  logic [CW-1:0]     add_slot_r;
  logic              del_ok_r;
  logic [NCNT_W-1:0] n_r;

  // dispatch word held back until we know whether it is the last one
  logic              hold_v_r;
  logic [CW-1:0]     hold_slot_r;
  logic [TAG_W-1:0]  hold_tag_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [TAG_W-1:0]  out_run_tag_r;
  logic              out_last_r;

  slot_t     ring_q [MAX_TASKS];
  slot_t     head_out;
  head_ctl_t ctl;
  logic      hit;
  logic      shift_en;
  logic      accept;

  logic [CW+SLOT_W-1:0] cnt_ext;
  logic [CW+SLOT_W-1:0] idx_ext;
  logic [CW+SLOT_W-1:0] add_ext;
  logic [CW+SLOT_W-1:0] hold_ext;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign shift_en = (state_r == S_RUN);

  // widen both sides so any table size compares and truncates cleanly
  assign cnt_ext  = {{SLOT_W{1'b0}}, cnt_r};
  assign idx_ext  = {{CW{1'b0}}, idx_r};
  assign add_ext  = {{SLOT_W{1'b0}}, add_slot_r};
  assign hold_ext = {{SLOT_W{1'b0}}, hold_slot_r};

  // ---------------------------------------------------------------------
  // Ring of slot cells: each shifts toward the head, tail takes head result
  // ---------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_ring
      slot_t cell_d;
      if (gi == MAX_TASKS - 1) begin : g_tail
        assign cell_d = head_out;
      end else begin : g_mid
        assign cell_d = ring_q[gi+1];
      end
      cts_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (cell_d),
        .q        (ring_q[gi])
      );
    end
  endgenerate

  always_comb begin
    ctl.op         = op_r;
    ctl.add_done   = add_done_r;
    ctl.del_hit    = (cnt_ext == idx_ext);
    ctl.disp_allow = (n_r < NCNT_W'(RESULT_LIMIT));
    ctl.tag        = tag_r;
    ctl.delay      = delay_r;
    ctl.period     = period_r;
  end

  cts_head u_head (
    .slot_in  (ring_q[0]),
    .ctl      (ctl),
    .slot_out (head_out),
    .hit      (hit)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cnt_r == CNT_END) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == S_RUN && op_r == OP_DISP && hit && hold_v_r) begin
        // a later ready slot exists: release the held word as not last
        out_valid_r <= 1'b1;
      end else if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Latch the command word on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_opcode);
      tag_r    <= in_task_tag;
      delay_r  <= in_first_delay;
      period_r <= in_repeat_period;
      idx_r    <= in_slot_index;
    end
  end

  // Per-pass bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      add_done_r <= 1'b0;
      del_ok_r   <= 1'b0;
      n_r        <= '0;
      hold_v_r   <= 1'b0;
    end else if (accept) begin
      cnt_r      <= '0;
      add_done_r <= 1'b0;
      del_ok_r   <= 1'b0;
      n_r        <= '0;
      hold_v_r   <= 1'b0;
    end else if (state_r == S_RUN) begin
      cnt_r <= (cnt_r == CNT_END) ? '0 : cnt_r + 1'b1;
      if (hit) begin
        case (op_r)
          OP_ADD: begin
            add_done_r <= 1'b1;
          end
          OP_DEL: begin
            del_ok_r <= 1'b1;
          end
          OP_DISP: begin
            hold_v_r <= 1'b1;
            n_r      <= n_r + 1'b1;
          end
          default: begin
            del_ok_r <= del_ok_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RUN && hit) begin
      if (op_r == OP_ADD) begin
        add_slot_r <= cnt_r;
      end
      if (op_r == OP_DISP) begin
        hold_slot_r <= cnt_r;
        hold_tag_r  <= ring_q[0].data.tag;
      end
    end
  end

  // Result word payload
  always_ff @(posedge clk) begin
    if (state_r == S_RUN && op_r == OP_DISP && hit && hold_v_r) begin
      out_status_r  <= ST_OK;
      out_slot_r    <= hold_ext[SLOT_W-1:0];
      out_run_tag_r <= hold_tag_r;
      out_last_r    <= 1'b0;
    end else if (state_r == S_DONE) begin
      out_last_r    <= 1'b1;
      out_run_tag_r <= '0;
      out_slot_r    <= '0;
      out_status_r  <= ST_OK;
      case (op_r)
        OP_ADD: begin
          if (add_done_r) begin
            out_slot_r <= add_ext[SLOT_W-1:0];
          end else begin
            out_status_r <= ST_FULL;
          end
        end
        OP_DEL: begin
          out_slot_r   <= idx_r;
          out_status_r <= del_ok_r ? ST_OK : ST_BAD;
        end
        OP_TICK: begin
          out_status_r <= ST_OK;
        end
        OP_DISP: begin
          if (hold_v_r) begin
            out_slot_r    <= hold_ext[SLOT_W-1:0];
            out_run_tag_r <= hold_tag_r;
          end else begin
            out_status_r <= ST_NONE;
          end
        end
        default: begin
          out_status_r <= ST_OK;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_run_tag = out_run_tag_r;
  assign out_last    = out_last_r;

endmodule
